@@ rtl/lqt_pkg.sv @@
`timescale 1ns / 1ps

package lqt_pkg;

	localparam int FRAC_BITS = 10;

	// quality word: 0 .. ONE inclusive
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int ALPHA_W   = 11;
	localparam int MINLQ_W   = 11;
	localparam int COST_W    = 24;
	localparam int BYTE_W    = 8;
	localparam int ACTION_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = COST_W;

	// qualities and register values compared at a common width
	localparam int QCMP_W = (Q_W > ALPHA_W) ? Q_W : ALPHA_W;

	// multiplier: Q_W x Q_W
	localparam int PROD_W    = 2 * Q_W;
	localparam int MUL_CNT_W = $clog2(Q_W + 1);

	// divider: dividend up to 2^(2*FRAC_BITS)
	localparam int DVD_W     = 2 * FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);
	localparam int CMP_W     = (DVD_W > COST_W) ? DVD_W : COST_W;

	localparam logic [Q_W-1:0]   ONE_Q       = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DVD_W-1:0] ONE_SQ      = {1'b1, {(2 * FRAC_BITS){1'b0}}};
	localparam logic [Q_W-1:0]   BYTE_MAX_Q  = Q_W'(255);

	localparam logic [ALPHA_W-1:0] ALPHA_RST       = ALPHA_W'(51);
	localparam logic [MINLQ_W-1:0] MINLQ_RST       = MINLQ_W'(102);
	localparam logic [COST_W-1:0]  COST_BROKEN_RST = COST_W'(1048576);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHA       = 2'd0,
		REG_MIN_LQ      = 2'd1,
		REG_COST_BROKEN = 2'd2
	} reg_idx_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_HELLO_RX   = 2'd0,
		ACT_HELLO_LOST = 2'd1,
		ACT_NLQ_REPORT = 2'd2,
		ACT_CLEAR      = 2'd3
	} action_t;

endpackage

@@ rtl/lqt_serial_mul.sv @@
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module lqt_serial_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lqt_pkg::Q_W-1:0]   mcand,
	input  logic [lqt_pkg::Q_W-1:0]   mplier,
	output logic                      done,
	output logic [lqt_pkg::PROD_W-1:0] prod
);

	logic [lqt_pkg::Q_W-1:0]       mcand_q;
	logic [lqt_pkg::PROD_W:0]      acc_q;
	logic [lqt_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lqt_pkg::Q_W:0]         hi_sum;

	// add the multiplicand into the upper half when the low bit is set
	assign hi_sum = acc_q[lqt_pkg::PROD_W:lqt_pkg::Q_W]
		+ (acc_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lqt_pkg::MUL_CNT_W'(lqt_pkg::Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lqt_pkg::MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= {{(lqt_pkg::Q_W + 1){1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {1'b0, hi_sum, acc_q[lqt_pkg::Q_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q[lqt_pkg::PROD_W-1:0];

endmodule

@@ rtl/lqt_serial_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module lqt_serial_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lqt_pkg::DVD_W-1:0] dividend,
	input  logic [lqt_pkg::Q_W-1:0]   divisor,
	output logic                     done,
	output logic [lqt_pkg::DVD_W-1:0] quotient
);

	logic [lqt_pkg::DVD_W-1:0]     num_q;
	logic [lqt_pkg::Q_W-1:0]       rem_q;
	logic [lqt_pkg::Q_W-1:0]       dsr_q;
	logic [lqt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [lqt_pkg::Q_W:0]         trial;
	logic [lqt_pkg::Q_W:0]         diff;
	logic                          fits;

	assign trial = {rem_q, num_q[lqt_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= lqt_pkg::DIV_CNT_W'(lqt_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lqt_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits Q_W bits
			rem_q <= fits ? diff[lqt_pkg::Q_W-1:0] : trial[lqt_pkg::Q_W-1:0];
			num_q <= {num_q[lqt_pkg::DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ rtl/etx_link_quality_tracker.sv @@
`timescale 1ns / 1ps

// Link quality tracker for one link with ETX cost.
// Input stream: one beat per event. s_tuser carries the action (hello received,
// hello lost, neighbor report, clear), s_tdata the neighbor's report byte.
// Output stream: one beat per event with the ETX cost and both qualities as
// bytes. Configuration (alpha, min_lq, cost_broken) is written through
// cfg_we/cfg_index/cfg_data by the user only while no event is in flight;
// the block does not enforce this. One event is worked at a time; s_tready
// is high only when the block is free. A broken link skips the cost multiply
// and divide, a zero product skips the divide. s_tready rises with m_tvalid.
// One shift-add multiplier (aging, lq*nlq) and one restoring divider (report
// scaling, cost quotient) do the arithmetic, one bit per cycle each.
// The result sits in an output register; the next event is taken while it
// waits. If the receiver stalls, a finished event holds in the last state
// until the output register frees up.
// Reset clears both qualities to zero and loads the default registers.
module etx_link_quality_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] report_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [23:0] link_cost, [31:24] lq_byte, [39:32] nlq_byte
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_AGE  = 7'b0000010,
		S_NLQ  = 7'b0000100,
		S_COST = 7'b0001000,
		S_PROD = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [lqt_pkg::ALPHA_W-1:0] alpha_q;
	logic [lqt_pkg::MINLQ_W-1:0] min_lq_q;
	logic [lqt_pkg::COST_W-1:0]  cost_broken_q;

	logic [lqt_pkg::Q_W-1:0]    lq_q;
	logic [lqt_pkg::Q_W-1:0]    nlq_q;
	logic                       rx_q;
	logic [lqt_pkg::COST_W-1:0] cost_q;

	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	logic                         s_beat;
	lqt_pkg::action_t             act;
	logic [lqt_pkg::Q_W-1:0]      a_eff;
	logic [lqt_pkg::Q_W-1:0]      one_minus_a;
	logic                         mul_start;
	logic [lqt_pkg::Q_W-1:0]      mul_b;
	logic                         mul_done;
	logic [lqt_pkg::PROD_W-1:0]   mul_prod;
	logic [lqt_pkg::Q_W-1:0]      prod_sh;
	logic                         div_start;
	logic [lqt_pkg::DVD_W-1:0]    div_dvd;
	logic [lqt_pkg::Q_W-1:0]      div_dsr;
	logic                         div_done;
	logic [lqt_pkg::DVD_W-1:0]    div_quo;
	logic                         broken;
	logic                         out_free;
	logic [lqt_pkg::COST_W-1:0]   cost_out;
	logic [lqt_pkg::Q_W+7:0]      lq_x255;
	logic [lqt_pkg::Q_W+7:0]      nlq_x255;

	assign s_beat   = s_tvalid && s_tready;
	assign act      = lqt_pkg::action_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// alpha above one counts as one
	assign a_eff = (lqt_pkg::QCMP_W'(alpha_q) > lqt_pkg::QCMP_W'(lqt_pkg::ONE_Q))
		? lqt_pkg::ONE_Q : lqt_pkg::Q_W'(alpha_q);
	assign one_minus_a = lqt_pkg::ONE_Q - a_eff;

	assign broken = (lqt_pkg::QCMP_W'(lq_q) < lqt_pkg::QCMP_W'(min_lq_q))
		|| (lqt_pkg::QCMP_W'(nlq_q) < lqt_pkg::QCMP_W'(min_lq_q));

	assign prod_sh = mul_prod[lqt_pkg::FRAC_BITS +: lqt_pkg::Q_W];

	// multiplier operands: lq times (one - alpha) for aging, lq times nlq for cost
	assign mul_b     = (state_q == S_IDLE) ? one_minus_a : nlq_q;
	assign mul_start = (s_beat && (act == lqt_pkg::ACT_HELLO_RX
		|| act == lqt_pkg::ACT_HELLO_LOST))
		|| (state_q == S_COST && !broken);

	// divider operands: byte*ONE/255 for reports, ONE*ONE/prod for cost
	assign div_dvd   = (state_q == S_IDLE)
		? (lqt_pkg::DVD_W'(s_tdata) << lqt_pkg::FRAC_BITS) : lqt_pkg::ONE_SQ;
	assign div_dsr   = (state_q == S_IDLE) ? lqt_pkg::BYTE_MAX_Q : prod_sh;
	assign div_start = (s_beat && act == lqt_pkg::ACT_NLQ_REPORT)
		|| (state_q == S_PROD && mul_done && prod_sh != '0);

	lqt_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (lq_q),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	lqt_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign cost_out = (cost_q == '0) ? lqt_pkg::COST_W'(1) : cost_q;
	assign lq_x255  = ({8'd0, lq_q} << 8) - {8'd0, lq_q};
	assign nlq_x255 = ({8'd0, nlq_q} << 8) - {8'd0, nlq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q       <= lqt_pkg::ALPHA_RST;
			min_lq_q      <= lqt_pkg::MINLQ_RST;
			cost_broken_q <= lqt_pkg::COST_BROKEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lqt_pkg::REG_ALPHA:       alpha_q       <= cfg_data[lqt_pkg::ALPHA_W-1:0];
				lqt_pkg::REG_MIN_LQ:      min_lq_q      <= cfg_data[lqt_pkg::MINLQ_W-1:0];
				lqt_pkg::REG_COST_BROKEN: cost_broken_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lq_q       <= '0;
			nlq_q      <= '0;
			rx_q       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_beat) begin
						rx_q <= (act == lqt_pkg::ACT_HELLO_RX);
						unique case (act)
							lqt_pkg::ACT_HELLO_RX,
							lqt_pkg::ACT_HELLO_LOST: state_q <= S_AGE;
							lqt_pkg::ACT_NLQ_REPORT: state_q <= S_NLQ;
							lqt_pkg::ACT_CLEAR: begin
								lq_q    <= '0;
								nlq_q   <= '0;
								state_q <= S_COST;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_AGE: begin
					if (mul_done) begin
						lq_q    <= prod_sh + (rx_q ? a_eff : '0);
						state_q <= S_COST;
					end
				end
				S_NLQ: begin
					if (div_done) begin
						nlq_q   <= div_quo[lqt_pkg::Q_W-1:0];
						state_q <= S_COST;
					end
				end
				S_COST: begin
					state_q <= broken ? S_OUT : S_PROD;
				end
				S_PROD: begin
					if (mul_done)
						state_q <= (prod_sh == '0) ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// cost payload: broken value unless a quotient arrives, capped at the broken value
	always_ff @(posedge clk) begin
		if (state_q == S_COST && broken)
			cost_q <= cost_broken_q;
		if (state_q == S_PROD && mul_done && prod_sh == '0)
			cost_q <= cost_broken_q;
		if (state_q == S_DIV && div_done)
			cost_q <= (lqt_pkg::CMP_W'(div_quo) > lqt_pkg::CMP_W'(cost_broken_q))
				? cost_broken_q : lqt_pkg::COST_W'(div_quo);
		if (state_q == S_OUT && out_free)
			m_tdata_q <= {nlq_x255[lqt_pkg::FRAC_BITS +: lqt_pkg::BYTE_W],
				lq_x255[lqt_pkg::FRAC_BITS +: lqt_pkg::BYTE_W], cost_out};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_lq_range: assert property (@(posedge clk) disable iff (!arst_n)
		lq_q <= lqt_pkg::ONE_Q && nlq_q <= lqt_pkg::ONE_Q)
		else $error("quality above one");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_AGE || state_q == S_PROD))
		else $error("multiplier finished with no owner");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_NLQ || state_q == S_DIV))
		else $error("divider finished with no owner");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_tready)
		else $error("input taken again before event finished");

endmodule

@@ verif/lqt_cost_checker.sv @@
`timescale 1ns / 1ps

module lqt_cost_checker
	import lqt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] report_byte
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // [23:0] link_cost, [31:24] lq_byte, [39:32] nlq_byte
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic [COST_W-1:0] cost;
		logic [BYTE_W-1:0] lq_b;
		logic [BYTE_W-1:0] nlq_b;
	} link_report_t;

	link_report_t due_reports[$];

	logic [ALPHA_W-1:0] alpha_q;
	logic [MINLQ_W-1:0] min_lq_q;
	logic [COST_W-1:0]  cost_broken_q;
	logic [Q_W-1:0]     lq_q;
	logic [Q_W-1:0]     nlq_q;

	function automatic logic [BYTE_W-1:0] quality_byte(input logic [Q_W-1:0] q);
		logic [31:0] scaled;
		scaled = 32'(q) * 32'd255;
		return scaled[FRAC_BITS +: BYTE_W];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		link_report_t want;
		link_report_t got;
		logic [63:0]  eff_alpha;
		logic [63:0]  prod;
		logic [63:0]  cost;
		if (!arst_n) begin
			alpha_q       = ALPHA_RST;
			min_lq_q      = MINLQ_RST;
			cost_broken_q = COST_BROKEN_RST;
			lq_q          = '0;
			nlq_q         = '0;
			due_reports.delete();
			errors        = 0;
			pending       = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ALPHA:       alpha_q       = cfg_data[ALPHA_W-1:0];
					REG_MIN_LQ:      min_lq_q      = cfg_data[MINLQ_W-1:0];
					REG_COST_BROKEN: cost_broken_q = cfg_data[COST_W-1:0];
					default: ;
				endcase
			end

			if (m_tvalid && m_tready) begin
				got.cost  = m_tdata[23:0];
				got.lq_b  = m_tdata[31:24];
				got.nlq_b = m_tdata[39:32];
				if (due_reports.size() == 0) begin
					$display("%0t: result beat with nothing due: cost %0d lq %0d nlq %0d",
						$time, got.cost, got.lq_b, got.nlq_b);
					errors++;
				end else begin
					want = due_reports.pop_front();
					if (got.cost !== want.cost) begin
						$display("%0t: link_cost expected %0d got %0d", $time, want.cost, got.cost);
						errors++;
					end
					if (got.lq_b !== want.lq_b) begin
						$display("%0t: lq_byte expected %0d got %0d", $time, want.lq_b, got.lq_b);
						errors++;
					end
					if (got.nlq_b !== want.nlq_b) begin
						$display("%0t: nlq_byte expected %0d got %0d", $time,
							want.nlq_b, got.nlq_b);
						errors++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				// alpha above one counts as one
				eff_alpha = (64'(alpha_q) > 64'(ONE_Q)) ? 64'(ONE_Q) : 64'(alpha_q);
				case (action_t'(s_tuser))
					ACT_HELLO_RX:
						lq_q = Q_W'(((64'(lq_q) * (64'(ONE_Q) - eff_alpha)) >> FRAC_BITS)
							+ eff_alpha);
					ACT_HELLO_LOST:
						lq_q = Q_W'((64'(lq_q) * (64'(ONE_Q) - eff_alpha)) >> FRAC_BITS);
					ACT_NLQ_REPORT:
						nlq_q = Q_W'((64'(s_tdata) << FRAC_BITS) / 64'd255);
					default: begin
						lq_q  = '0;
						nlq_q = '0;
					end
				endcase

				if (64'(lq_q) < 64'(min_lq_q) || 64'(nlq_q) < 64'(min_lq_q)) begin
					cost = 64'(cost_broken_q);
				end else begin
					prod = (64'(lq_q) * 64'(nlq_q)) >> FRAC_BITS;
					if (prod == 0) begin
						cost = 64'(cost_broken_q);
					end else begin
						cost = (64'd1 << (2 * FRAC_BITS)) / prod;
						if (cost > 64'(cost_broken_q))
							cost = 64'(cost_broken_q);
					end
				end
				if (cost == 0)
					cost = 64'd1;

				want.cost  = cost[COST_W-1:0];
				want.lq_b  = quality_byte(lq_q);
				want.nlq_b = quality_byte(nlq_q);
				due_reports.push_back(want);
			end
			pending = due_reports.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import lqt_pkg::*;

	typedef enum logic [1:0] {
		RX_OPEN    = 2'd0,
		RX_COIN    = 2'd1,
		RX_CHOKED  = 2'd2,
		RX_PULSE   = 2'd3
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;    // [7:0] report_byte
	logic [1:0]  s_tuser = '0;    // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [23:0] link_cost, [31:24] lq_byte, [39:32] nlq_byte
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;

	int errors;
	int pending;

	int       burst_left = 0;
	bit       steady = 1'b0;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	etx_link_quality_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lqt_cost_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver: switch at random between stall patterns
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'(2'($urandom_range(0, 3)));
			rx_left <= $urandom_range(40, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_CHOKED: m_tready <= ($urandom_range(0, 7) == 0);
			default:   m_tready <= (rx_tick % 5) < 2;
		endcase
	end

	task automatic send_event(input action_t act, input logic [7:0] rb);
		if (!steady && burst_left == 0) begin
			// idle gap with junk on the data lines
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			s_tuser  <= 2'($urandom);
			repeat ($urandom_range(0, 9)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= rb;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	// registers change only with the block idle
	task automatic configure(input logic [23:0] a, input logic [23:0] m, input logic [23:0] c);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ALPHA;
		cfg_data  <= a;
		@(negedge clk);
		cfg_index <= REG_MIN_LQ;
		cfg_data  <= m;
		@(negedge clk);
		cfg_index <= REG_COST_BROKEN;
		cfg_data  <= c;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_event();
		int         pick;
		logic [7:0] rb;
		pick = $urandom_range(0, 99);
		rb   = 8'($urandom);
		if (pick < 50) begin
			send_event(ACT_HELLO_RX, rb);
		end else if (pick < 70) begin
			send_event(ACT_HELLO_LOST, rb);
		end else if (pick < 96) begin
			// lean toward good neighbors so the cost leaves the broken value
			if ($urandom_range(0, 2) != 0)
				rb = 8'($urandom_range(120, 255));
			send_event(ACT_NLQ_REPORT, rb);
		end else begin
			send_event(ACT_CLEAR, rb);
		end
	endtask

	initial begin
		logic [23:0] a;
		logic [23:0] m;
		logic [23:0] c;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: broken link, full neighbor, aging up and down
		send_event(ACT_CLEAR, 8'hFF);
		send_event(ACT_NLQ_REPORT, 8'd255);
		repeat (6) send_event(ACT_HELLO_RX, 8'h00);
		send_event(ACT_HELLO_LOST, 8'hFF);
		send_event(ACT_NLQ_REPORT, 8'd0);
		send_event(ACT_NLQ_REPORT, 8'd1);
		send_event(ACT_NLQ_REPORT, 8'd128);
		send_event(ACT_HELLO_RX, 8'hAA);
		send_event(ACT_NLQ_REPORT, 8'hFF);
		send_event(ACT_HELLO_LOST, 8'h55);
		send_event(ACT_CLEAR, 8'h00);
		send_event(ACT_HELLO_RX, 8'h5A);

		// register extremes, including alpha above one and a zero broken cost
		configure(24'd1024, 24'd0, 24'hFFFFFF);
		send_event(ACT_HELLO_RX, 8'h00);
		send_event(ACT_NLQ_REPORT, 8'd1);
		send_event(ACT_NLQ_REPORT, 8'd0);
		send_event(ACT_NLQ_REPORT, 8'd255);
		send_event(ACT_CLEAR, 8'hFF);
		repeat (25) random_event();
		configure(24'd0, 24'd1024, 24'd1);
		repeat (25) random_event();
		configure(24'd2047, 24'd2047, 24'd0);
		repeat (25) random_event();
		configure(24'd1, 24'd1, 24'd1);
		repeat (25) random_event();
		configure(24'd1500, 24'd0, 24'd0);
		repeat (25) random_event();

		for (int ph = 0; ph < 12; ph++) begin
			a = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 2047))
				: 24'($urandom_range(16, 400));
			m = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 2047))
				: 24'($urandom_range(0, 700));
			case ($urandom_range(0, 3))
				0:       c = 24'($urandom);
				1:       c = 24'($urandom_range(0, 4096));
				2:       c = 24'($urandom_range(1000, 1 << 21));
				default: c = 24'hFFFFFF;
			endcase
			configure(a, m, c);
			steady = (ph % 3 == 0);
			repeat (135) random_event();
		end
		steady = 1'b0;

		drain();
		repeat (80) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

endmodule
